>>> design/oldest_first_exit_arbiter_unit_defines.svh
`ifndef OLDEST_FIRST_EXIT_ARBITER_UNIT_DEFINES_SVH
`define OLDEST_FIRST_EXIT_ARBITER_UNIT_DEFINES_SVH

// Implication checked in the same cycle, held off during reset.
`define OFEA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent, held off during reset.
`define OFEA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ofea_pkg.sv
`timescale 1ns / 1ps
package ofea_pkg;

    localparam int MAX_PORTS = 16;
    localparam int PORT_W    = 4;
    localparam int CNT_W     = 5;

    localparam logic [CNT_W-1:0] PORTS_IN_USE_RESET = 5'd16;

    localparam int UPC_W = 3;
    typedef logic [UPC_W-1:0] upc_t;
    typedef logic [PORT_W-1:0] port_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam upc_t ST_IDLE  = 3'd0;
    localparam upc_t ST_SCAN1 = 3'd1;
    localparam upc_t ST_CHECK = 3'd2;
    localparam upc_t ST_SCAN2 = 3'd3;
    localparam upc_t ST_EMIT  = 3'd4;

    localparam logic [2:0] C_ALWAYS   = 3'd0;
    localparam logic [2:0] C_ACCEPT   = 3'd1;
    localparam logic [2:0] C_LAST     = 3'd2;
    localparam logic [2:0] C_FOUND    = 3'd3;
    localparam logic [2:0] C_OUT_FREE = 3'd4;

    typedef struct packed {
        logic [2:0] cond;
        logic       dispatch;
        upc_t       jump;
        upc_t       other;
        logic       take_cmd;
        logic       scan1;
        logic       init2;
        logic       scan2;
        logic       emit;
    } ctl_t;

    function automatic ctl_t ofea_ucode(input upc_t upc);
        ctl_t w;
        w = '{cond: C_ALWAYS, dispatch: 1'b0, jump: ST_IDLE, other: ST_IDLE,
              take_cmd: 1'b0, scan1: 1'b0, init2: 1'b0, scan2: 1'b0, emit: 1'b0};
        unique case (upc)
            ST_IDLE:
            begin
                w.cond     = C_ACCEPT;
                w.dispatch = 1'b1;
                w.jump     = ST_SCAN1;
                w.other    = ST_IDLE;
                w.take_cmd = 1'b1;
            end
            ST_SCAN1:
            begin
                w.cond  = C_LAST;
                w.jump  = ST_CHECK;
                w.other = ST_SCAN1;
                w.scan1 = 1'b1;
            end
            ST_CHECK:
            begin
                w.cond  = C_FOUND;
                w.jump  = ST_SCAN2;
                w.other = ST_EMIT;
                w.init2 = 1'b1;
            end
            ST_SCAN2:
            begin
                w.cond  = C_LAST;
                w.jump  = ST_EMIT;
                w.other = ST_SCAN2;
                w.scan2 = 1'b1;
            end
            ST_EMIT:
            begin
                w.cond  = C_OUT_FREE;
                w.jump  = ST_IDLE;
                w.other = ST_EMIT;
                w.emit  = 1'b1;
            end
            default:
            begin
                w.cond = C_ALWAYS;
                w.jump = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> design/ofea_ifs.sv
`timescale 1ns / 1ps
interface ofea_cmd_if #(parameter int TIME_WIDTH = 32);
    logic                  valid;
    logic                  ready;
    logic                  operation;
    logic [3:0]            port_index;
    logic [TIME_WIDTH-1:0] port_request_time;
    logic [3:0]            port_target_exit;
    logic                  port_target_valid;
    logic [TIME_WIDTH-1:0] head_time;
    logic                  head_present;
    logic [3:0]            exit_index;
    logic [TIME_WIDTH-1:0] current_time;

    modport source (
        output valid, operation, port_index, port_request_time, port_target_exit,
        output port_target_valid, head_time, head_present, exit_index, current_time,
        input  ready
    );
    modport sink (
        input  valid, operation, port_index, port_request_time, port_target_exit,
        input  port_target_valid, head_time, head_present, exit_index, current_time,
        output ready
    );
endinterface

interface ofea_res_if;
    logic       valid;
    logic       ready;
    logic       grant_valid;
    logic [3:0] grant_port;
    logic [4:0] tie_count;
    logic [3:0] tie_least;
    logic [3:0] tie_greatest;

    modport source (
        output valid, grant_valid, grant_port, tie_count, tie_least, tie_greatest,
        input  ready
    );
    modport sink (
        input  valid, grant_valid, grant_port, tie_count, tie_least, tie_greatest,
        output ready
    );
endinterface

>>> design/oldest_first_exit_arbiter_unit.sv
`timescale 1ns / 1ps
// Oldest-first exit arbiter for a switch with sixteen entry ports.
// The cmd channel carries one word per request: an update word overwrites the
// status of one entry port, an arbitrate word names an exit and the current time.
// The res channel returns exactly one word per cmd word; an update word and an
// arbitration without an eligible port return all fields zero.
// The cfg port sets the number of entry ports in use; write it only when idle.
// A small microcode table sequences a plain datapath: one step takes a word,
// two scans visit the sixteen port records one per cycle, and one step loads
// the result register.
// An update goes from the step that takes it straight to the result step. An
// arbitration runs the first scan and a check step, then the second scan when a
// port is granted, before the result step.
// cmd.ready is high only while the sequencer waits for a new word. When the
// receiver stalls, the result stays in the output register and the sequencer
// still takes and works the next word, holding it in the final step until the
// output register is free.
// Reset clears all port records, the exit times and the output valid flag, and
// sets the number of ports in use to sixteen.
`include "oldest_first_exit_arbiter_unit_defines.svh"
module oldest_first_exit_arbiter_unit #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [ofea_pkg::CNT_W-1:0] cfg_wdata,
    ofea_cmd_if.sink               cmd,
    ofea_res_if.source             res
);
    import ofea_pkg::*;

    typedef logic [TIME_WIDTH-1:0] tm_t;

    cnt_t ports_in_use_reg;

    tm_t  req_time_reg   [MAX_PORTS];
    tm_t  head_time_reg  [MAX_PORTS];
    port_t reg_exit_reg  [MAX_PORTS];
    logic [MAX_PORTS-1:0] reg_valid_reg;
    logic [MAX_PORTS-1:0] head_pres_reg;
    tm_t  exit_last_reg  [MAX_PORTS];

    upc_t  upc_reg, upc_next;
    ctl_t  ctl;
    port_t idx_reg;
    port_t exit_reg;
    tm_t   now_reg;
    logic  found_reg;
    tm_t   oldest_reg;
    port_t pick_reg;
    cnt_t  count_reg;
    port_t least_reg;
    port_t greatest_reg;

    logic  res_valid_reg;
    logic  res_grant_reg;
    port_t res_port_reg;
    cnt_t  res_count_reg;
    port_t res_least_reg;
    port_t res_greatest_reg;

    logic  accept;
    logic  out_free;
    logic  last;
    logic  elig;
    logic  cond_true;

    assign ctl       = ofea_ucode(upc_reg);
    assign cmd.ready = ctl.take_cmd;
    assign accept    = cmd.valid && ctl.take_cmd;
    assign out_free  = !res_valid_reg || res.ready;
    assign last      = (idx_reg == port_t'(MAX_PORTS - 1));

    assign elig = ({1'b0, idx_reg} < ports_in_use_reg)
               && (idx_reg != exit_reg)
               && (req_time_reg[idx_reg] <= now_reg)
               && reg_valid_reg[idx_reg]
               && (reg_exit_reg[idx_reg] == exit_reg)
               && head_pres_reg[idx_reg];

    always_comb
    begin
        unique case (ctl.cond)
            C_ALWAYS:   cond_true = 1'b1;
            C_ACCEPT:   cond_true = accept;
            C_LAST:     cond_true = last;
            C_FOUND:    cond_true = found_reg;
            C_OUT_FREE: cond_true = out_free;
            default:    cond_true = 1'b1;
        endcase
        if (cond_true)
        begin
            if (ctl.dispatch && !cmd.operation)
            begin
                upc_next = ST_EMIT;
            end
            else
            begin
                upc_next = ctl.jump;
            end
        end
        else
        begin
            upc_next = ctl.other;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg          <= ST_IDLE;
            ports_in_use_reg <= PORTS_IN_USE_RESET;
        end
        else
        begin
            upc_reg <= upc_next;
            if (cfg_we)
            begin
                ports_in_use_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PORTS; i++)
            begin
                req_time_reg[i]  <= '0;
                head_time_reg[i] <= '0;
                reg_exit_reg[i]  <= '0;
                exit_last_reg[i] <= '0;
            end
            reg_valid_reg <= '0;
            head_pres_reg <= '0;
        end
        else
        begin
            if (accept && !cmd.operation)
            begin
                req_time_reg[cmd.port_index]  <= cmd.port_request_time;
                head_time_reg[cmd.port_index] <= cmd.head_time;
                reg_exit_reg[cmd.port_index]  <= cmd.port_target_exit;
                reg_valid_reg[cmd.port_index] <= cmd.port_target_valid;
                head_pres_reg[cmd.port_index] <= cmd.head_present;
            end
            if (ctl.init2 && found_reg)
            begin
                exit_last_reg[exit_reg] <= now_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            pick_reg     <= '0;
            count_reg    <= '0;
            least_reg    <= '0;
            greatest_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                idx_reg      <= '0;
                found_reg    <= 1'b0;
                pick_reg     <= '0;
                count_reg    <= '0;
                least_reg    <= '0;
                greatest_reg <= '0;
            end
            if (ctl.scan1)
            begin
                idx_reg <= idx_reg + port_t'(1);
                if (elig && (!found_reg || (head_time_reg[idx_reg] < oldest_reg)))
                begin
                    found_reg <= 1'b1;
                    pick_reg  <= idx_reg;
                end
            end
            if (ctl.init2)
            begin
                idx_reg      <= '0;
                count_reg    <= '0;
                least_reg    <= pick_reg;
                greatest_reg <= pick_reg;
            end
            if (ctl.scan2)
            begin
                idx_reg <= idx_reg + port_t'(1);
                if (elig && (head_time_reg[idx_reg] == oldest_reg))
                begin
                    count_reg <= count_reg + cnt_t'(1);
                    if (idx_reg < least_reg)
                    begin
                        least_reg <= idx_reg;
                    end
                    if (idx_reg > greatest_reg)
                    begin
                        greatest_reg <= idx_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            exit_reg <= cmd.exit_index;
            now_reg  <= cmd.current_time;
        end
        if (ctl.scan1 && elig && (!found_reg || (head_time_reg[idx_reg] < oldest_reg)))
        begin
            oldest_reg <= head_time_reg[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctl.emit && out_free)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit && out_free)
        begin
            res_grant_reg    <= found_reg;
            res_port_reg     <= pick_reg;
            res_count_reg    <= count_reg;
            res_least_reg    <= least_reg;
            res_greatest_reg <= (count_reg == cnt_t'(1)) ? '0 : greatest_reg;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.grant_valid  = res_grant_reg;
    assign res.grant_port   = res_port_reg;
    assign res.tie_count    = res_count_reg;
    assign res.tie_least    = res_least_reg;
    assign res.tie_greatest = res_greatest_reg;

    `OFEA_ASSERT_NEXT(a_arb_starts_scan, accept && cmd.operation,
        upc_reg == ST_SCAN1 && idx_reg == '0, "arbitration did not start a scan")
    `OFEA_ASSERT_NOW(a_found_has_tie, upc_reg == ST_EMIT && found_reg,
        count_reg != '0, "granted port missing from tie count")
    `OFEA_ASSERT_NOW(a_grant_is_least, res.valid && res.grant_valid,
        res.tie_least == res.grant_port, "granted port is not the least tied index")
    `OFEA_ASSERT_NEXT(a_no_spurious_word, out_free && upc_reg != ST_EMIT,
        !res.valid, "result word appeared outside the emit step")

endmodule
